// ----- src/bcc_pkg.sv -----
// Shared types and constants for the button click classifier.
package bcc_pkg;

   localparam int unsigned TimeW = 32;
   localparam int unsigned CfgW  = 16;

   localparam logic [CfgW-1:0] LongPressReset = 16'd800;
   localparam logic [CfgW-1:0] DoubleGapReset = 16'd250;
   localparam logic [CfgW-1:0] DebounceReset  = 16'd35;

   typedef enum logic [1:0] {
      CSR_LONG_PRESS = 2'd0,
      CSR_DOUBLE_GAP = 2'd1,
      CSR_DEBOUNCE   = 2'd2,
      CSR_DOUBLE_EN  = 2'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_SHORT  = 2'd1,
      EV_LONG   = 2'd2,
      EV_DOUBLE = 2'd3
   } event_type;

   typedef enum logic {
      OP_POLL   = 1'b0,
      OP_RESYNC = 1'b1
   } op_type;

   typedef struct packed {
      logic [CfgW-1:0] long_press_time;
      logic [CfgW-1:0] double_gap_time;
      logic [CfgW-1:0] debounce_time;
      logic            double_click_enable;
   } cfg_type;

endpackage

// ----- src/bcc_if.sv -----
// Handshake channel interfaces for poll items and event items.
interface bcc_req_if;
   import bcc_pkg::*;
   logic             valid;
   logic             ready;
   logic             op;
   logic             raw_level;
   logic [TimeW-1:0] now_ms;

   modport source (output valid, op, raw_level, now_ms, input ready);
   modport sink   (input valid, op, raw_level, now_ms, output ready);
endinterface

interface bcc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] event_res;

   modport source (output valid, event_res, input ready);
   modport sink   (input valid, event_res, output ready);
endinterface

// ----- src/bcc_csr.sv -----
// Configuration register bank.
module bcc_csr
   import bcc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_we,
   input  logic [1:0]      csr_addr,
   input  logic [CfgW-1:0] csr_wdata,
   output cfg_type         cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_idx_type'(csr_addr))
            CSR_LONG_PRESS: cfg_in.long_press_time     = csr_wdata;
            CSR_DOUBLE_GAP: cfg_in.double_gap_time     = csr_wdata;
            CSR_DEBOUNCE:   cfg_in.debounce_time       = csr_wdata;
            CSR_DOUBLE_EN:  cfg_in.double_click_enable = csr_wdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_press_time     <= LongPressReset;
         cfg_ff.double_gap_time     <= DoubleGapReset;
         cfg_ff.debounce_time       <= DebounceReset;
         cfg_ff.double_click_enable <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- src/bcc_engine.sv -----
// Debounce and click classification state, updated once per item.
module bcc_engine
   import bcc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             step_en,
   input  logic             op,
   input  logic             raw_level,
   input  logic [TimeW-1:0] now_ms,
   output event_type        event_out
);

   logic [TimeW-1:0] press_stamp_ff, press_stamp_in;
   logic [TimeW-1:0] release_stamp_ff, release_stamp_in;
   logic [TimeW-1:0] raw_change_stamp_ff, raw_change_stamp_in;
   logic held_ff, held_in;
   logic awaiting_ff, awaiting_in;
   logic long_done_ff, long_done_in;
   logic last_raw_ff, last_raw_in;
   logic stable_ff, stable_in;

   logic [TimeW-1:0] change_diff, press_diff, release_diff;
   logic             raw_changed, settled, level;
   event_type        ev;

   assign change_diff  = now_ms - raw_change_stamp_ff;
   assign press_diff   = now_ms - press_stamp_ff;
   assign release_diff = now_ms - release_stamp_ff;
   assign raw_changed  = raw_level != last_raw_ff;

   // a fresh raw edge means zero elapsed time
   assign settled = raw_changed ? (cfg.debounce_time == '0)
                                : (change_diff >= {{(TimeW-CfgW){1'b0}}, cfg.debounce_time});
   assign level   = ((raw_level != stable_ff) && settled) ? raw_level : stable_ff;

   always_comb begin
      press_stamp_in      = press_stamp_ff;
      release_stamp_in    = release_stamp_ff;
      raw_change_stamp_in = raw_changed ? now_ms : raw_change_stamp_ff;
      held_in             = held_ff;
      awaiting_in         = awaiting_ff;
      long_done_in        = long_done_ff;
      last_raw_in         = raw_level;
      stable_in           = level;
      ev                  = EV_NONE;

      if (op_type'(op) == OP_RESYNC) begin
         held_in             = raw_level;
         awaiting_in         = 1'b0;
         long_done_in        = raw_level;
         stable_in           = raw_level;
         press_stamp_in      = now_ms;
         release_stamp_in    = '0;
         raw_change_stamp_in = now_ms;
      end else begin
         unique case ({level, held_ff})
            2'b10: begin
               held_in        = 1'b1;
               press_stamp_in = now_ms;
               long_done_in   = 1'b0;
               if (cfg.double_click_enable && awaiting_ff) begin
                  awaiting_in  = 1'b0;
                  long_done_in = 1'b1;
                  ev           = EV_DOUBLE;
               end
            end
            2'b01: begin
               held_in = 1'b0;
               if (!long_done_ff &&
                   (press_diff > {{(TimeW-CfgW){1'b0}}, cfg.debounce_time})) begin
                  if (cfg.double_click_enable) begin
                     awaiting_in      = 1'b1;
                     release_stamp_in = now_ms;
                  end else begin
                     ev = EV_SHORT;
                  end
               end
            end
            2'b11: begin
               if (!long_done_ff &&
                   (press_diff > {{(TimeW-CfgW){1'b0}}, cfg.long_press_time})) begin
                  long_done_in = 1'b1;
                  awaiting_in  = 1'b0;
                  ev           = EV_LONG;
               end
            end
            default: begin
               if (cfg.double_click_enable && awaiting_ff &&
                   (release_diff > {{(TimeW-CfgW){1'b0}}, cfg.double_gap_time})) begin
                  awaiting_in = 1'b0;
                  ev          = EV_SHORT;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_stamp_ff      <= '0;
         release_stamp_ff    <= '0;
         raw_change_stamp_ff <= '0;
         held_ff             <= 1'b0;
         awaiting_ff         <= 1'b0;
         long_done_ff        <= 1'b0;
         last_raw_ff         <= 1'b0;
         stable_ff           <= 1'b0;
      end else if (step_en) begin
         press_stamp_ff      <= press_stamp_in;
         release_stamp_ff    <= release_stamp_in;
         raw_change_stamp_ff <= raw_change_stamp_in;
         held_ff             <= held_in;
         awaiting_ff         <= awaiting_in;
         long_done_ff        <= long_done_in;
         last_raw_ff         <= last_raw_in;
         stable_ff           <= stable_in;
      end
   end

   assign event_out = ev;

endmodule

// ----- src/button_click_classifier_top.sv -----
// Each item passes the input register, then the output register, to become an event item.
// Throughput: one item per clock while events are taken; an input register
// and an output register let a new item enter while a finished event waits to be taken.
// The classifier state updates once per item as it moves into the output register.
// Reset (synchronous, active high) empties both registers, clears all state and
// loads the configuration defaults.
module button_click_classifier_top
   import bcc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   bcc_req_if.sink         req_chan,
   bcc_rsp_if.source       rsp_chan,
   input  logic            csr_we,
   input  logic [1:0]      csr_addr,
   input  logic [CfgW-1:0] csr_wdata
);

   cfg_type cfg;

   logic             in_valid_ff, in_valid_in;
   logic             in_op_ff;
   logic             in_raw_ff;
   logic [TimeW-1:0] in_now_ff;
   logic             out_valid_ff, out_valid_in;
   logic [1:0]       out_event_ff;
   logic             out_load, in_load;
   event_type        ev;

   bcc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bcc_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .step_en   (out_load),
      .op        (in_op_ff),
      .raw_level (in_raw_ff),
      .now_ms    (in_now_ff),
      .event_out (ev)
   );

   assign out_load       = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || out_load;
   assign in_load        = req_chan.valid && req_chan.ready;
   assign in_valid_in    = in_load || (in_valid_ff && !out_load);
   assign out_valid_in   = out_load || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_op_ff  <= req_chan.op;
         in_raw_ff <= req_chan.raw_level;
         in_now_ff <= req_chan.now_ms;
      end
      if (out_load) begin
         out_event_ff <= ev;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.event_res = out_event_ff;

endmodule

// ----- src/bcc_checker.sv -----
// Port-level checks for the classifier top, attached by bind.
module bcc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_event
);

   // stalled event item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event))
      else $error("event item changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("event valid right after reset");

   // empty output register means the input side can always take an item
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   // an accepted item is followed by a valid event item
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> ##1 rsp_valid)
      else $error("accepted item produced no event");

endmodule

bind button_click_classifier_top bcc_checker u_bcc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_event (rsp_chan.event_res)
);
